[sv/cflt_pkg.sv]
package cflt_pkg;

  localparam int TABLE_ENTRIES = 128;

  localparam int CMD_W       = 2;
  localparam int ADDR_W      = 32;
  localparam int TIME_W      = 32;
  localparam int COUNT_W     = 8;
  localparam int DEADLINE_W  = TIME_W + 1;
  localparam int THRESHOLD_W = 8;
  localparam int BLOCK_W     = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = THRESHOLD_W'(3);
  localparam logic [BLOCK_W-1:0]     BLOCK_RESET     = BLOCK_W'(600);
  localparam logic [COUNT_W-1:0]     COUNT_MAX       = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CHECK   = 2'd0,
    CMD_FAILURE = 2'd1,
    CMD_SUCCESS = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 1'b0,
    REG_LOCK_SPAN = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [THRESHOLD_W-1:0] threshold;
    logic [BLOCK_W-1:0]     lock_span;
  } cfg_t;

  // request traveling down the row of cells
  typedef struct packed {
    logic               valid;
    logic               done;
    logic [CMD_W-1:0]   command;
    logic [ADDR_W-1:0]  client_ip;
    logic [TIME_W-1:0]  now;
    logic               blocked;
    logic [COUNT_W-1:0] count;
  } tok_t;

endpackage

[sv/cflt_ifs.sv]
interface cflt_in_if;
  logic                          valid;
  logic                          ready;
  logic [cflt_pkg::CMD_W-1:0]    command;
  logic [cflt_pkg::ADDR_W-1:0]   client_ip;
  logic [cflt_pkg::TIME_W-1:0]   now;

  modport source (output valid, command, client_ip, now, input ready);
  modport sink   (input valid, command, client_ip, now, output ready);
endinterface

interface cflt_out_if;
  logic                          valid;
  logic                          ready;
  logic                          blocked;
  logic [cflt_pkg::COUNT_W-1:0]  failure_count;
  logic                          no_slot;

  modport source (output valid, blocked, failure_count, no_slot, input ready);
  modport sink   (input valid, blocked, failure_count, no_slot, output ready);
endinterface

interface cflt_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [cflt_pkg::CFG_IDX_W-1:0]   index;
  logic [cflt_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/cflt_cell.sv]
module cflt_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  cflt_pkg::cfg_t cfg,
  input  cflt_pkg::tok_t tok_i,
  output cflt_pkg::tok_t tok_o
);

  logic                               used_r;
  logic [cflt_pkg::ADDR_W-1:0]        addr_r;
  logic [cflt_pkg::COUNT_W-1:0]       fail_r;
  logic [cflt_pkg::DEADLINE_W-1:0]    dl_r;
  logic                               tok_valid_r;
  cflt_pkg::tok_t                     tok_r;

  logic                               live;
  logic                               match;
  logic                               alloc;
  logic                               hit;
  logic [cflt_pkg::COUNT_W-1:0]       cur_f;
  logic [cflt_pkg::DEADLINE_W-1:0]    cur_d;
  logic [cflt_pkg::COUNT_W-1:0]       fail_nxt;
  logic [cflt_pkg::DEADLINE_W-1:0]    dl_nxt;
  logic [cflt_pkg::DEADLINE_W-1:0]    now_ext;
  cflt_pkg::tok_t                     tok_nxt;

  // used entries form a prefix, so the first free cell reached means absent
  always_comb begin
    live    = tok_i.valid & ~tok_i.done;
    match   = live & used_r & (addr_r == tok_i.client_ip);
    alloc   = live & ~used_r;
    hit     = match | alloc;
    cur_f   = alloc ? '0 : fail_r;
    cur_d   = alloc ? '0 : dl_r;
    now_ext = {1'b0, tok_i.now};
    fail_nxt = cur_f;
    dl_nxt   = cur_d;
    case (tok_i.command)
      cflt_pkg::CMD_FAILURE: begin
        if (cur_f != cflt_pkg::COUNT_MAX) begin
          fail_nxt = cur_f + cflt_pkg::COUNT_W'(1);
        end
        if (fail_nxt >= cfg.threshold) begin
          dl_nxt = now_ext + cflt_pkg::DEADLINE_W'(cfg.lock_span);
        end
      end
      cflt_pkg::CMD_SUCCESS: begin
        fail_nxt = '0;
        dl_nxt   = '0;
      end
      default: begin
      end
    endcase
    tok_nxt = tok_i;
    if (hit) begin
      tok_nxt.done    = 1'b1;
      tok_nxt.blocked = (dl_nxt > now_ext);
      tok_nxt.count   = fail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= 1'b0;
      tok_valid_r <= 1'b0;
    end else if (en) begin
      tok_valid_r <= tok_nxt.valid;
      if (hit) begin
        used_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tok_r <= tok_nxt;
      if (hit) begin
        addr_r <= tok_i.client_ip;
        fail_r <= fail_nxt;
        dl_r   <= dl_nxt;
      end
    end
  end

  always_comb begin
    tok_o       = tok_r;
    tok_o.valid = tok_valid_r;
  end

endmodule

[sv/client_failure_lockout_table.sv]
// channel   dir  handshake     payload
// in_ch     in   valid/ready   command, client_ip, now
// out_ch    out  valid/ready   blocked, failure_count, no_slot
// cfg_ch    in   valid/ready   index (0 threshold, 1 lock span), data
//
// a request walks the row of TABLE_ENTRIES cells, one cell per cycle while the row
// is not frozen, and its result then passes the output register before it is offered
// a new request may enter every cycle while the row is not frozen; the row holds one request per cell
// reset clears every used bit and every valid bit in the row, threshold 3, lock span 600
// a result left waiting on out_ch freezes the whole row and in_ch.ready
module client_failure_lockout_table (
  input logic        clk,
  input logic        rst_n,
  cflt_in_if.sink    in_ch,
  cflt_out_if.source out_ch,
  cflt_cfg_if.sink   cfg_ch
);

  cflt_pkg::cfg_t                 cfg_r;
  cflt_pkg::tok_t                 chain [cflt_pkg::TABLE_ENTRIES+1];
  logic                           en;
  logic                           out_valid_r;
  logic                           out_blocked_r;
  logic [cflt_pkg::COUNT_W-1:0]   out_count_r;
  logic                           out_no_slot_r;
  cflt_pkg::tok_t                 last;

  assign en           = ~out_valid_r | out_ch.ready;
  assign in_ch.ready  = en & rst_n;
  assign cfg_ch.ready = rst_n;

  always_comb begin
    chain[0].valid     = in_ch.valid;
    chain[0].done      = 1'b0;
    chain[0].command   = in_ch.command;
    chain[0].client_ip = in_ch.client_ip;
    chain[0].now       = in_ch.now;
    chain[0].blocked   = 1'b0;
    chain[0].count     = '0;
  end

  for (genvar i = 0; i < cflt_pkg::TABLE_ENTRIES; i++) begin : g_cell
    cflt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .cfg   (cfg_r),
      .tok_i (chain[i]),
      .tok_o (chain[i+1])
    );
  end

  assign last = chain[cflt_pkg::TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold <= cflt_pkg::THRESHOLD_RESET;
      cfg_r.lock_span <= cflt_pkg::BLOCK_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        cflt_pkg::REG_THRESHOLD:
          cfg_r.threshold <= cfg_ch.data[cflt_pkg::THRESHOLD_W-1:0];
        cflt_pkg::REG_LOCK_SPAN:
          cfg_r.lock_span <= cfg_ch.data[cflt_pkg::BLOCK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_blocked_r <= last.done & last.blocked;
      out_count_r   <= last.done ? last.count : '0;
      out_no_slot_r <= ~last.done;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.blocked       = out_blocked_r;
  assign out_ch.failure_count = out_count_r;
  assign out_ch.no_slot       = out_no_slot_r;

endmodule
